// ===== rtl/core/vki_pkg.sv =====
// shared types and constants for the vector keyframe interpolator
package vki_pkg;

  // field widths
  localparam int TIME_W = 24;
  localparam int VAL_W  = 32;
  localparam int FRAC_W = 16;
  localparam int SLOT_W = 6;
  localparam int KC_W   = 7;

  // default table depth
  localparam int DEF_MAX_KEYS = 64;

  // blend factor of exactly 1.0 in Q1.16
  localparam logic [FRAC_W:0] ONE_Q16 = {1'b1, {FRAC_W{1'b0}}};

  // key count after reset
  localparam logic [KC_W-1:0] KC_RESET = KC_W'(1);

  // command codes
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // register index decoded from paddr[2]
  localparam logic REG_KEY_COUNT = 1'b0;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_FETCH,
    S_FETCH2,
    S_FETCH3,
    S_PREP,
    S_DIV,
    S_MUL,
    S_ADD
  } vki_state_t;

endpackage

// ===== rtl/core/vector_keyframe_interpolator_core.sv =====
// vector keyframe interpolator: key table in ram, linear search, divide and blend
//
// channel   | handshake                      | payload
// ----------+--------------------------------+------------------------------------------
// input     | start, busy (beat: start & !busy) | in_command, in_key_slot, in_key_time,
//           |                                |   in_key_x/y/z, in_sample_time
// result    | out_valid, 1 cycle/sample beat | out_x, out_y, out_z, out_base_key
// config    | apb psel/penable/pwrite/pready | paddr, pwdata, prdata (key_count at 0x0)
//
// a write beat stores its key in the same edge and leaves busy low: one beat per cycle.
// a sample beat runs these steps in order: the pipelined search through the time ram read
//   port (skipped for a single key), S_FETCH to S_FETCH3 for fetching the two keys, S_PREP
//   to pick the factor, the bit-serial divider (skipped when the factor is 0 or 1.0), the
//   shared multiplier one lane at a time and the last add; out_valid follows as busy drops
//   and the next beat is taken at its end.
// reset is synchronous; it sets key_count to 1 and idles the sequencer; the ram is not
// cleared, so keys must be written before they are sampled. results cannot be stalled.
module vector_keyframe_interpolator_core #(
  parameter int MAX_KEYS = vki_pkg::DEF_MAX_KEYS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_command,
  input  logic [vki_pkg::SLOT_W-1:0]        in_key_slot,
  input  logic [vki_pkg::TIME_W-1:0]        in_key_time,
  input  logic signed [vki_pkg::VAL_W-1:0]  in_key_x,
  input  logic signed [vki_pkg::VAL_W-1:0]  in_key_y,
  input  logic signed [vki_pkg::VAL_W-1:0]  in_key_z,
  input  logic [vki_pkg::TIME_W-1:0]        in_sample_time,
  // result channel
  output logic                              out_valid,
  output logic signed [vki_pkg::VAL_W-1:0]  out_x,
  output logic signed [vki_pkg::VAL_W-1:0]  out_y,
  output logic signed [vki_pkg::VAL_W-1:0]  out_z,
  output logic [vki_pkg::SLOT_W-1:0]        out_base_key,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import vki_pkg::*;

  localparam int IDX_W  = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int VEC_W  = 3 * VAL_W;
  localparam int PROD_W = (VAL_W + 1) + (FRAC_W + 2);

  // registers
  vki_state_t                 state_r, state_nxt;
  logic [KC_W-1:0]            key_count_r;
  logic [TIME_W-1:0]          s_r;
  logic [CNT_W-1:0]           n_r;
  logic [CNT_W-1:0]           rd_ptr_r;
  logic [CNT_W-1:0]           cmp_ptr_r;
  logic                       cmp_vld_r;
  logic [IDX_W-1:0]           base_r;
  logic [IDX_W-1:0]           next_r;
  logic [TIME_W-1:0]          t_base_r;
  logic [TIME_W-1:0]          t_next_r;
  logic [2:0][VAL_W-1:0]      va_r;
  logic [2:0][VAL_W-1:0]      vb_r;
  logic [TIME_W-1:0]          rem_r;
  logic [TIME_W-1:0]          dvs_r;
  logic [FRAC_W-1:0]          quo_r;
  logic [3:0]                 div_cnt_r;
  logic [FRAC_W:0]            factor_r;
  logic [1:0]                 lane_r;
  logic [1:0]                 plane_r;
  logic                       pvld_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [VAL_W-1:0]           a_r;
  logic [2:0][VAL_W-1:0]      res_r;
  logic                       out_valid_r;

  // combinational signals
  logic                       in_beat;
  logic                       cfg_wr;
  logic                       slot_ok;
  logic                       key_we;
  logic [IDX_W-1:0]           key_waddr;
  logic [31:0]                n_wide;
  logic [CNT_W-1:0]           n_eff;
  logic [IDX_W-1:0]           raddr;
  logic [TIME_W-1:0]          t_rdata;
  logic [VEC_W-1:0]           v_rdata;
  logic [CNT_W-1:0]           ptr_dec;
  logic [CNT_W-1:0]           n_dec;
  logic [CNT_W-1:0]           base_inc;
  logic                       srch_hit;
  logic                       srch_end;
  logic [TIME_W:0]            rem2;
  logic                       rem_fits;
  logic [TIME_W-1:0]          rem_nxt;
  logic [FRAC_W-1:0]          quo_nxt;
  logic signed [VAL_W:0]      diff;
  logic signed [FRAC_W+1:0]   fac_s;

  // handshakes
  assign in_beat = start && !busy;
  assign busy    = (state_r != S_IDLE);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  // register read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_KEY_COUNT) begin
      prdata = 32'(key_count_r);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= KC_RESET;
    end else if (cfg_wr && paddr[2] == REG_KEY_COUNT) begin
      key_count_r <= pwdata[KC_W-1:0];
    end
  end

  // effective key count: zero acts as one, saturate at table depth
  always_comb begin
    n_wide = 32'(key_count_r);
    if (n_wide == 32'd0) begin
      n_wide = 32'd1;
    end else if (n_wide > 32'(MAX_KEYS)) begin
      n_wide = 32'(MAX_KEYS);
    end
    n_eff = CNT_W'(n_wide);
  end

  // key write path
  assign slot_ok   = (32'(in_key_slot) < 32'(MAX_KEYS));
  assign key_waddr = IDX_W'(32'(in_key_slot));
  assign key_we    = in_beat && (in_command == CMD_WRITE) && slot_ok;

  // shared read address for both tables
  always_comb begin
    unique case (state_r)
      S_SRCH:  raddr = rd_ptr_r[IDX_W-1:0];
      S_FETCH: raddr = base_r;
      default: raddr = next_r;
    endcase
  end

  vki_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_KEYS)
  ) u_time_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (in_key_time),
    .raddr (raddr),
    .rdata (t_rdata)
  );

  vki_ram #(
    .WIDTH (VEC_W),
    .DEPTH (MAX_KEYS)
  ) u_vec_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata ({in_key_z, in_key_y, in_key_x}),
    .raddr (raddr),
    .rdata (v_rdata)
  );

  // search compare on the time returned for cmp_ptr_r
  assign ptr_dec  = cmp_ptr_r - CNT_W'(1);
  assign n_dec    = n_r - CNT_W'(1);
  assign base_inc = CNT_W'(base_r) + CNT_W'(1);
  assign srch_hit = cmp_vld_r && (s_r < t_rdata);
  assign srch_end = cmp_vld_r && (cmp_ptr_r == n_dec);

  // restoring divider step, one quotient bit per cycle
  assign rem2     = {rem_r, 1'b0};
  assign rem_fits = (rem2 >= {1'b0, dvs_r});
  assign rem_nxt  = rem_fits ? TIME_W'(rem2 - {1'b0, dvs_r}) : rem2[TIME_W-1:0];
  assign quo_nxt  = {quo_r[FRAC_W-2:0], rem_fits};

  // blend operands for the current lane
  assign diff  = {vb_r[lane_r][VAL_W-1], vb_r[lane_r]} - {va_r[lane_r][VAL_W-1], va_r[lane_r]};
  assign fac_s = {1'b0, factor_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat && in_command == CMD_SAMPLE) begin
          state_nxt = (n_eff == CNT_W'(1)) ? S_FETCH : S_SRCH;
        end
      end
      S_SRCH: begin
        if (srch_hit || srch_end) begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH:  state_nxt = S_FETCH2;
      S_FETCH2: state_nxt = S_FETCH3;
      S_FETCH3: state_nxt = S_PREP;
      S_PREP: begin
        priority if (t_next_r <= t_base_r) begin
          state_nxt = S_MUL;
        end else if (s_r <= t_base_r || s_r >= t_next_r) begin
          state_nxt = S_MUL;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt_r == 4'hf) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        if (lane_r == 2'd2) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cmp_vld_r   <= 1'b0;
      pvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      lane_r      <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pvld_r      <= (state_r == S_MUL);
      out_valid_r <= (state_r == S_ADD);
      if (state_r == S_SRCH) begin
        cmp_vld_r <= (rd_ptr_r < n_r);
      end else begin
        cmp_vld_r <= 1'b0;
      end
      if (state_r == S_MUL) begin
        lane_r <= (lane_r == 2'd2) ? 2'd0 : lane_r + 2'd1;
      end else begin
        lane_r <= '0;
      end
      if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r + 4'd1;
      end else begin
        div_cnt_r <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    // any beat latches time and count and sets up the search
    if (state_r == S_IDLE && in_beat) begin
      s_r      <= in_sample_time;
      n_r      <= n_eff;
      rd_ptr_r <= CNT_W'(1);
      base_r   <= '0;
    end

    // search: one read issued, one compare per cycle
    if (state_r == S_SRCH) begin
      rd_ptr_r  <= rd_ptr_r + CNT_W'(1);
      cmp_ptr_r <= rd_ptr_r;
      if (srch_hit) begin
        base_r <= ptr_dec[IDX_W-1:0];
      end else if (srch_end) begin
        base_r <= n_dec[IDX_W-1:0];
      end
    end

    // next key, clamped to the last key
    if (state_r == S_FETCH) begin
      next_r <= (base_inc >= n_r) ? base_r : base_inc[IDX_W-1:0];
    end

    // capture both keys
    if (state_r == S_FETCH2) begin
      t_base_r <= t_rdata;
      va_r     <= v_rdata;
    end
    if (state_r == S_FETCH3) begin
      t_next_r <= t_rdata;
      vb_r     <= v_rdata;
    end

    // factor: special cases or divider setup
    if (state_r == S_PREP) begin
      rem_r <= s_r - t_base_r;
      dvs_r <= t_next_r - t_base_r;
      quo_r <= '0;
      priority if (t_next_r <= t_base_r) begin
        factor_r <= ONE_Q16;
      end else if (s_r <= t_base_r) begin
        factor_r <= '0;
      end else if (s_r >= t_next_r) begin
        factor_r <= ONE_Q16;
      end else begin
        factor_r <= factor_r;
      end
    end

    // divider iterations
    if (state_r == S_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      if (div_cnt_r == 4'hf) begin
        factor_r <= {1'b0, quo_nxt};
      end
    end

    // shared multiplier, one lane per cycle
    if (state_r == S_MUL) begin
      prod_r  <= diff * fac_s;
      a_r     <= va_r[lane_r];
      plane_r <= lane_r;
    end

    // add stage: start plus floored scaled difference
    if (pvld_r) begin
      res_r[plane_r] <= a_r + prod_r[FRAC_W+VAL_W-1:FRAC_W];
    end
  end

  // result outputs
  assign out_valid    = out_valid_r;
  assign out_x        = res_r[0];
  assign out_y        = res_r[1];
  assign out_z        = res_r[2];
  assign out_base_key = SLOT_W'(32'(base_r));

  // a result appears as the block goes idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // busy only rises after a sample beat
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_command == CMD_SAMPLE))
    else $error("busy without sample beat");

  // search compares stay inside the valid keys
  a_srch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH && cmp_vld_r) |-> (cmp_ptr_r < n_r && cmp_ptr_r != '0))
    else $error("search pointer out of range");

  // blend factor never exceeds one
  a_factor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (factor_r <= ONE_Q16))
    else $error("blend factor above one");

endmodule

// ===== rtl/core/vki_ram.sv =====
// generic single write, single read ram with registered read data
module vki_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
